// ----- hdl/tmfc_pkg.sv -----
`default_nettype none

package tmfc_pkg;

    // frame layout
    localparam int unsigned DATA_FIELD_BYTES = 1016;
    localparam int unsigned HDR_LEN          = 6;
    localparam int unsigned CRC_HI_POS       = HDR_LEN + DATA_FIELD_BYTES;
    localparam int unsigned CRC_LO_POS       = CRC_HI_POS + 1;
    localparam int unsigned FRAME_LEN        = CRC_HI_POS + 2;

    localparam int unsigned POS_W   = 12;
    localparam int unsigned HDR_W   = 8 * HDR_LEN;

    localparam logic [POS_W-1:0] POS_MAX       = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] POS_HDR_END   = POS_W'(HDR_LEN);
    localparam logic [POS_W-1:0] POS_CRC_HI    = POS_W'(CRC_HI_POS);
    localparam logic [POS_W-1:0] POS_CRC_LO    = POS_W'(CRC_LO_POS);
    localparam logic [POS_W-1:0] POS_LAST_BYTE = POS_W'(FRAME_LEN - 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_CRC_FAIL  = 2'd1,
        STATUS_TRUNCATED = 2'd2
    } status_t;

    // byte-wide crc-16 update, msb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/tm_frame_checker.sv -----
`default_nettype none
// a taken byte lands in the input register, then its result in the result register,
// which loads when that register is free or being drained; one byte per cycle
// sustained, set by the combinational byte-wide crc update between the two registers;
// a stalled result holds off input
// reset (aresetn low, synchronous): both stages empty, position 0, crc 0xffff,
// header and received crc cleared; the same frame state returns after each
// end-of-frame byte

module tm_frame_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input channel
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [7:0]   s_rx_byte,
    input  wire logic         s_end_of_frame,
    // result channel
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [7:0]        m_echo_byte,
    output logic              m_is_payload,
    output logic              m_frame_done,
    output logic [1:0]        m_check_status,
    output logic [1:0]        m_version_no,
    output logic [9:0]        m_spacecraft_id,
    output logic [2:0]        m_virtual_chan,
    output logic              m_ocf_present,
    output logic [7:0]        m_master_count,
    output logic [7:0]        m_vc_count,
    output logic [10:0]       m_first_hdr_ptr,
    output logic [4:0]        m_df_flags
);
    import tmfc_pkg::*;

    // input register stage
    logic             in_vld_reg;
    logic [7:0]       in_byte_reg;
    logic             in_eof_reg;

    // frame state
    logic [POS_W-1:0] byte_pos_reg,  byte_pos_next;
    logic [15:0]      crc_acc_reg,   crc_acc_next;
    logic [HDR_W-1:0] header_reg,    header_next;
    logic [7:0]       rx_crc_hi_reg, rx_crc_hi_next;
    logic             crc_match_reg, crc_match_next;

    // result register stage
    logic             out_vld_reg;
    logic [7:0]       echo_reg;
    logic             payload_reg;
    logic             done_reg;
    status_t          status_reg,    status_next;
    logic [HDR_W-1:0] hdr_out_reg,   hdr_out_next;

    logic             advance;
    logic             crc_match_now;
    logic             payload_next;

    // the input stage moves on whenever the result register is free or being drained
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    // per-byte processing between the two register stages
    always_comb begin
        byte_pos_next  = byte_pos_reg;
        crc_acc_next   = crc_acc_reg;
        header_next    = header_reg;
        rx_crc_hi_next = rx_crc_hi_reg;
        crc_match_next = crc_match_reg;
        payload_next   = 1'b0;

        // header bytes shift in, first byte ends up most significant
        if (byte_pos_reg < POS_HDR_END) begin
            header_next = {header_reg[HDR_W-9:0], in_byte_reg};
        end

        // crc covers header and data field; the two bytes after it are the received word
        if (byte_pos_reg < POS_CRC_HI) begin
            crc_acc_next = crc16_byte(crc_acc_reg, in_byte_reg);
            payload_next = (byte_pos_reg >= POS_HDR_END);
        end else if (byte_pos_reg == POS_CRC_HI) begin
            rx_crc_hi_next = in_byte_reg;
        end else if (byte_pos_reg == POS_CRC_LO) begin
            crc_match_next = ({rx_crc_hi_reg, in_byte_reg} == crc_acc_reg);
        end

        // position saturates so a long buffer never wraps into a new frame
        if (byte_pos_reg != POS_MAX) begin
            byte_pos_next = byte_pos_reg + 1'b1;
        end

        crc_match_now = crc_match_next;
    end

    // end-of-frame status and header fields
    always_comb begin
        status_next  = STATUS_OK;
        hdr_out_next = '0;
        if (in_eof_reg) begin
            if (byte_pos_reg < POS_LAST_BYTE) begin
                status_next = STATUS_TRUNCATED;
            end else begin
                status_next  = crc_match_now ? STATUS_OK : STATUS_CRC_FAIL;
                hdr_out_next = header_next;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
            byte_pos_reg  <= '0;
            crc_acc_reg   <= CRC_INIT;
            header_reg    <= '0;
            rx_crc_hi_reg <= '0;
            crc_match_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
            if (advance) begin
                // a frame's last byte puts the state back to its reset value
                if (in_eof_reg) begin
                    byte_pos_reg  <= '0;
                    crc_acc_reg   <= CRC_INIT;
                    header_reg    <= '0;
                    rx_crc_hi_reg <= '0;
                    crc_match_reg <= 1'b0;
                end else begin
                    byte_pos_reg  <= byte_pos_next;
                    crc_acc_reg   <= crc_acc_next;
                    header_reg    <= header_next;
                    rx_crc_hi_reg <= rx_crc_hi_next;
                    crc_match_reg <= crc_match_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
            in_eof_reg  <= s_end_of_frame;
        end
        if (advance) begin
            echo_reg    <= in_byte_reg;
            payload_reg <= payload_next;
            done_reg    <= in_eof_reg;
            status_reg  <= status_next;
            hdr_out_reg <= hdr_out_next;
        end
    end

    // unpack header words 0..2 onto the result ports
    assign m_valid         = out_vld_reg;
    assign m_echo_byte     = echo_reg;
    assign m_is_payload    = payload_reg;
    assign m_frame_done    = done_reg;
    assign m_check_status  = status_reg;
    assign m_version_no    = hdr_out_reg[47:46];
    assign m_spacecraft_id = hdr_out_reg[45:36];
    assign m_virtual_chan  = hdr_out_reg[35:33];
    assign m_ocf_present   = hdr_out_reg[32];
    assign m_master_count  = hdr_out_reg[31:24];
    assign m_vc_count      = hdr_out_reg[23:16];
    assign m_df_flags      = hdr_out_reg[15:11];
    assign m_first_hdr_ptr = hdr_out_reg[10:0];

endmodule

`default_nettype wire

// ----- hdl/tmfc_checker.sv -----
`default_nettype none

module tmfc_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         m_valid,
    input wire logic         m_ready,
    input wire logic [7:0]   m_echo_byte,
    input wire logic         m_frame_done,
    input wire logic [1:0]   m_check_status,
    input wire logic [9:0]   m_spacecraft_id,
    input wire logic [10:0]  m_first_hdr_ptr,
    input wire logic [7:0]   m_master_count
);
    import tmfc_pkg::*;

    // status and header fields only carry meaning on the last byte of a frame
    a_idle_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_frame_done |->
            m_check_status == STATUS_OK && m_spacecraft_id == 10'd0 &&
            m_first_hdr_ptr == 11'd0 && m_master_count == 8'd0)
        else $error("status or header nonzero on a non-final byte");

    // a truncated frame reports no header
    a_trunc_no_header: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_check_status == STATUS_TRUNCATED |->
            m_spacecraft_id == 10'd0 && m_first_hdr_ptr == 11'd0 &&
            m_master_count == 8'd0)
        else $error("header reported on a truncated frame");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_check_status == STATUS_OK || m_check_status == STATUS_CRC_FAIL ||
                    m_check_status == STATUS_TRUNCATED)
        else $error("undefined status code");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_echo_byte) && $stable(m_frame_done))
        else $error("result transfer dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind tm_frame_checker tmfc_checker u_tmfc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_echo_byte     (m_echo_byte),
    .m_frame_done    (m_frame_done),
    .m_check_status  (m_check_status),
    .m_spacecraft_id (m_spacecraft_id),
    .m_first_hdr_ptr (m_first_hdr_ptr),
    .m_master_count  (m_master_count)
);

`default_nettype wire

// ----- tb/sv/tm_frame_checker_tb.sv -----
`timescale 1ns / 1ps

module tm_frame_checker_tb;
    import tmfc_pkg::*;

    // cycles with no transfer on either channel before the run is called hung
    localparam int unsigned STALL_LIMIT = 2000;
    // a byte's result only has the input and result registers to pass, so a short tail is plenty
    localparam int unsigned TAIL_CYCLES = 8;

    typedef logic [7:0] byte_q_t[$];

    // one expected result: the byte echo plus the header summary on the last byte
    typedef struct packed {
        logic [7:0]  echo;
        logic        payload;
        logic        done;
        status_t     status;
        logic [1:0]  version;
        logic [9:0]  scid;
        logic [2:0]  vcid;
        logic        ocf;
        logic [7:0]  mc_count;
        logic [7:0]  vc_count;
        logic [10:0] fhp;
        logic [4:0]  df_flags;
    } byte_verdict_t;

    // clock, reset and block inputs, all known from time zero
    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        s_end_of_frame = 1'b0;
    logic        m_ready = 1'b0;

    // block outputs
    logic        s_ready;
    logic        m_valid;
    logic [7:0]  m_echo_byte;
    logic        m_is_payload;
    logic        m_frame_done;
    logic [1:0]  m_check_status;
    logic [1:0]  m_version_no;
    logic [9:0]  m_spacecraft_id;
    logic [2:0]  m_virtual_chan;
    logic        m_ocf_present;
    logic [7:0]  m_master_count;
    logic [7:0]  m_vc_count;
    logic [10:0] m_first_hdr_ptr;
    logic [4:0]  m_df_flags;

    // chance in a hundred that the sender or the receiver holds off in a cycle
    int unsigned src_idle_pct = 33;
    int unsigned snk_idle_pct = 33;

    // frame tracking state of the predictor
    logic [11:0] fr_pos;
    logic [15:0] fr_crc;
    logic [47:0] fr_hdr;
    logic [7:0]  fr_rx_hi;
    logic        fr_match;

    // expected results, oldest first
    byte_verdict_t verdict_q[$];
    byte_verdict_t oldest;

    int unsigned fail_count = 0;
    int unsigned n_bytes = 0;
    int unsigned n_ok = 0;
    int unsigned n_crc_bad = 0;
    int unsigned n_trunc = 0;
    int unsigned n_past_end = 0;
    int unsigned n_saturated = 0;
    int unsigned stall_cycles = 0;

    tm_frame_checker DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .s_end_of_frame  (s_end_of_frame),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_echo_byte     (m_echo_byte),
        .m_is_payload    (m_is_payload),
        .m_frame_done    (m_frame_done),
        .m_check_status  (m_check_status),
        .m_version_no    (m_version_no),
        .m_spacecraft_id (m_spacecraft_id),
        .m_virtual_chan  (m_virtual_chan),
        .m_ocf_present   (m_ocf_present),
        .m_master_count  (m_master_count),
        .m_vc_count      (m_vc_count),
        .m_first_hdr_ptr (m_first_hdr_ptr),
        .m_df_flags      (m_df_flags)
    );

    // 8 ns clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // crc-16, poly 0x1021, one data bit at a time, msb first
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] d);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb  = crc[15] ^ d[i];
            crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return crc;
    endfunction

    // back to the start-of-frame state
    task automatic frame_restart();
        fr_pos   = '0;
        fr_crc   = CRC_INIT;
        fr_hdr   = '0;
        fr_rx_hi = '0;
        fr_match = 1'b0;
    endtask

    // works out the result of one accepted byte and queues it
    task automatic predict_byte(input logic [7:0] rx, input logic eof);
        byte_verdict_t v;
        int unsigned   pos;
        logic [15:0]   w0;
        logic [15:0]   w1;
        logic [15:0]   w2;
        v    = '0;
        pos  = fr_pos;
        v.echo = rx;
        n_bytes++;

        // header bytes shift in, first byte ends up on top
        if (pos < HDR_LEN)
            fr_hdr = {fr_hdr[39:0], rx};
        // crc covers header and data field; data field bytes are payload
        if (pos < CRC_HI_POS) begin
            fr_crc    = crc_step(fr_crc, rx);
            v.payload = (pos >= HDR_LEN);
        end else if (pos == CRC_HI_POS) begin
            fr_rx_hi = rx;
        end else if (pos == CRC_LO_POS) begin
            fr_match = ({fr_rx_hi, rx} == fr_crc);
        end else begin
            n_past_end++;
        end

        // position holds at its top value
        if (fr_pos != POS_MAX)
            fr_pos = fr_pos + 1'b1;

        if (eof) begin
            v.done = 1'b1;
            if (pos == POS_MAX)
                n_saturated++;
            if (pos + 1 < FRAME_LEN) begin
                // frame ended early: header fields stay zero
                v.status = STATUS_TRUNCATED;
                n_trunc++;
            end else begin
                w0 = fr_hdr[47:32];
                w1 = fr_hdr[31:16];
                w2 = fr_hdr[15:0];
                v.status   = fr_match ? STATUS_OK : STATUS_CRC_FAIL;
                v.version  = w0[15:14];
                v.scid     = w0[13:4];
                v.vcid     = w0[3:1];
                v.ocf      = w0[0];
                v.mc_count = w1[15:8];
                v.vc_count = w1[7:0];
                v.fhp      = w2[10:0];
                v.df_flags = w2[15:11];
                if (fr_match)
                    n_ok++;
                else
                    n_crc_bad++;
            end
            frame_restart();
        end
        verdict_q.push_back(v);
    endtask

    // one byte on the input channel; valid stays up from one transfer to the next
    // unless the sender decides to idle first
    task automatic send_byte(input logic [7:0] rx, input logic eof);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_rx_byte      <= rx;
        s_end_of_frame <= eof;
        do @(posedge aclk); while (!s_ready);
        predict_byte(rx, eof);
    endtask

    // whole buffer, end_of_frame on its last byte
    task automatic send_buffer(input byte_q_t octets);
        foreach (octets[i])
            send_byte(octets[i], i == octets.size() - 1);
    endtask

    // sender holds off until every expected result is out
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (verdict_q.size() != 0)
            @(posedge aclk);
    endtask

    // full-length frame with a correct crc word
    function automatic byte_q_t build_frame(input logic [47:0] hdr, input bit rand_data,
                                            input logic [7:0] fill);
        byte_q_t     octets;
        logic [15:0] crc;
        crc = CRC_INIT;
        for (int i = HDR_LEN - 1; i >= 0; i--)
            octets.push_back(hdr[8*i +: 8]);
        for (int i = 0; i < DATA_FIELD_BYTES; i++)
            octets.push_back(rand_data ? 8'($urandom_range(255)) : fill);
        foreach (octets[i])
            crc = crc_step(crc, octets[i]);
        octets.push_back(crc[15:8]);
        octets.push_back(crc[7:0]);
        return octets;
    endfunction

    function automatic logic [47:0] rand_header();
        return {16'($urandom()), 32'($urandom())};
    endfunction

    // flips one bit somewhere in [lo, hi]
    function automatic byte_q_t flip_bit(input byte_q_t octets, input int unsigned lo,
                                         input int unsigned hi);
        int unsigned k;
        k = $urandom_range(hi, lo);
        octets[k] = octets[k] ^ (8'h01 << $urandom_range(7, 0));
        return octets;
    endfunction

    function automatic byte_q_t trim_to(input byte_q_t octets, input int unsigned n);
        while (octets.size() > n)
            void'(octets.pop_back());
        return octets;
    endfunction

    // a few frames that end early, byte values at both extremes
    task automatic test_short_frames();
        send_buffer('{8'hFF});
        send_buffer('{8'h00});
        send_buffer('{8'hA5, 8'h5A});
        // header only, end on its last byte
        send_buffer('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        // one data byte past the header, so one payload flag
        send_buffer('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF});
    endtask

    // good frames with every header field at its top and bottom value
    task automatic test_header_extremes();
        send_buffer(build_frame(48'hFFFF_FFFF_FFFF, 1'b0, 8'hFF));
        send_buffer(build_frame(48'h0000_0000_0000, 1'b0, 8'h00));
        send_buffer(build_frame(48'hAAAA_5555_A5A5, 1'b1, 8'h00));
    endtask

    // frames that stop one and two bytes short of the crc word's end, and one with a single data byte
    task automatic test_length_edges();
        send_buffer(trim_to(build_frame(rand_header(), 1'b1, 8'h00), FRAME_LEN - 1));
        send_buffer(trim_to(build_frame(rand_header(), 1'b1, 8'h00), FRAME_LEN - 2));
        send_buffer(trim_to(build_frame(rand_header(), 1'b1, 8'h00), HDR_LEN + 1));
    endtask

    // single bit errors in crc word, data field and header
    task automatic test_crc_errors();
        send_buffer(flip_bit(build_frame(rand_header(), 1'b1, 8'h00), FRAME_LEN - 1,
                             FRAME_LEN - 1));
        send_buffer(flip_bit(build_frame(rand_header(), 1'b1, 8'h00), HDR_LEN,
                             CRC_HI_POS - 1));
        send_buffer(flip_bit(build_frame(rand_header(), 1'b1, 8'h00), 0, HDR_LEN - 1));
    endtask

    // buffer longer than the frame: trailing bytes echo only
    task automatic test_trailing_bytes();
        byte_q_t octets;
        octets = build_frame(rand_header(), 1'b1, 8'h00);
        repeat (20) octets.push_back(8'($urandom_range(255)));
        send_buffer(octets);
        octets = flip_bit(build_frame(rand_header(), 1'b1, 8'h00), FRAME_LEN - 2, FRAME_LEN - 2);
        repeat (3) octets.push_back(8'($urandom_range(255)));
        send_buffer(octets);
    endtask

    // buffer well past the 12-bit position range, end flag after it has stuck
    task automatic test_position_saturation();
        byte_q_t octets;
        octets = build_frame(rand_header(), 1'b1, 8'h00);
        while (octets.size() < 4200)
            octets.push_back(8'($urandom_range(255)));
        send_buffer(octets);
    endtask

    // neither side holds off for two whole frames
    task automatic test_back_to_back();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_buffer(build_frame(rand_header(), 1'b1, 8'h00));
        send_buffer(flip_bit(build_frame(rand_header(), 1'b1, 8'h00), 0, FRAME_LEN - 1));
        src_idle_pct = 33;
        snk_idle_pct = 33;
    endtask

    // frames with random content: cut short in over half the cases, else whole or long, some damaged
    task automatic test_random_frames();
        byte_q_t     octets;
        int unsigned sent;
        int unsigned full_seen;
        int unsigned kind;
        sent      = 0;
        full_seen = 0;
        while (sent < 500 || full_seen < 10) begin
            kind   = $urandom_range(99);
            octets = build_frame(rand_header(), 1'b1, 8'h00);
            if (kind < 45) begin
                octets = trim_to(octets, $urandom_range(40, 1));
            end else if (kind < 55) begin
                octets = trim_to(octets, $urandom_range(FRAME_LEN - 1, FRAME_LEN - 6));
            end else if (kind < 85) begin
                if ($urandom_range(2) == 0)
                    octets = flip_bit(octets, 0, FRAME_LEN - 1);
                full_seen++;
            end else begin
                if ($urandom_range(3) == 0)
                    octets = flip_bit(octets, 0, FRAME_LEN - 1);
                repeat ($urandom_range(40, 1)) octets.push_back(8'($urandom_range(255)));
                full_seen++;
            end
            send_buffer(octets);
            sent += octets.size();
            if ($urandom_range(19) == 0)
                wait_for_drain();
        end
    endtask

    // receiver stalls at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // every result transfer is matched against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $error("unexpected result transfer: echo_byte %0h", m_echo_byte);
                fail_count++;
            end else begin
                oldest = verdict_q.pop_front();
                check_field("echo_byte", oldest.echo, m_echo_byte);
                check_field("is_payload", oldest.payload, m_is_payload);
                check_field("frame_done", oldest.done, m_frame_done);
                check_field("check_status", oldest.status, m_check_status);
                check_field("version_no", oldest.version, m_version_no);
                check_field("spacecraft_id", oldest.scid, m_spacecraft_id);
                check_field("virtual_chan", oldest.vcid, m_virtual_chan);
                check_field("ocf_present", oldest.ocf, m_ocf_present);
                check_field("master_count", oldest.mc_count, m_master_count);
                check_field("vc_count", oldest.vc_count, m_vc_count);
                check_field("first_hdr_ptr", oldest.fhp, m_first_hdr_ptr);
                check_field("df_flags", oldest.df_flags, m_df_flags);
            end
        end
    end

    // hang detector: any transfer on either channel restarts the count
    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("tm_frame_checker_tb: FAIL");
        $finish;
    end

    initial begin
        frame_restart();
        // reset held from time zero, released once
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_short_frames();
        test_header_extremes();
        wait_for_drain();
        test_length_edges();
        test_crc_errors();
        test_trailing_bytes();
        wait_for_drain();
        test_position_saturation();
        test_back_to_back();
        wait_for_drain();
        test_random_frames();

        // let the pipeline empty out, then give it a few more edges
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d bytes: %0d good frames, %0d crc errors, %0d cut short",
                 n_bytes, n_ok, n_crc_bad, n_trunc);
        $display("%0d bytes past a frame end, %0d frame(s) ending with the position stuck",
                 n_past_end, n_saturated);
        if (fail_count == 0 && verdict_q.size() == 0) begin
            $display("tm_frame_checker_tb: PASS");
        end else begin
            $display("tm_frame_checker_tb: FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/tmfc_pkg.sv
hdl/tm_frame_checker.sv
hdl/tmfc_checker.sv
tb/sv/tm_frame_checker_tb.sv
